@@ hw/rtl/rba_pkg.sv @@
package rba_pkg;

	// Pool size and fixed field widths.
	localparam int NUM_BUFFERS = 4;
	localparam int BUF_IDX_W   = $clog2(NUM_BUFFERS);
	localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);
	localparam int PORT_W      = 8;
	localparam int TAG_W       = 8;
	localparam int TYPE_W      = 2;
	localparam int SEQ_W       = 8;
	localparam int TOTAL_W     = 8;
	localparam int OUTCOME_W   = 3;
	localparam int RCNT_W      = 5;
	localparam int LIMIT_W     = 5;
	localparam int REC_W       = TAG_W + TOTAL_W + TYPE_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT = 2'd1;
	localparam logic               MODE_RR     = 1'b0;
	localparam logic               MODE_JSQ    = 1'b1;
	localparam logic               MODE_RESET  = MODE_JSQ;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

	// Commands.
	localparam logic CMD_ARRIVE  = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Result outcomes.
	typedef enum logic [OUTCOME_W-1:0] {
		OUT_MORE      = 3'd0,
		OUT_DONE      = 3'd1,
		OUT_DROP      = 3'd2,
		OUT_REL       = 3'd3,
		OUT_REL_EMPTY = 3'd4
	} outcome_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOD,
		ST_PICK,
		ST_PUSH,
		ST_RD,
		ST_REL,
		ST_OUT
	} state_t;

	// Flags from the shared compare unit for the buffer under inspection.
	typedef struct packed {
		logic eligible;
		logic match;
		logic room;
		logic shorter;
	} unit_flags_t;

endpackage

@@ hw/rtl/rba_req_if.sv @@
interface rba_req_if;
	import rba_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 cmd;
	logic [BUF_IDX_W-1:0] buffer_index;
	logic [PORT_W-1:0]    source_port;
	logic [TAG_W-1:0]     stream_tag;
	logic [TYPE_W-1:0]    pkt_type;
	logic [SEQ_W-1:0]     seq_num;
	logic [TOTAL_W-1:0]   total_packets;

	modport source (
		output valid, cmd, buffer_index, source_port, stream_tag, pkt_type, seq_num,
			total_packets,
		input  ready
	);
	modport sink (
		input  valid, cmd, buffer_index, source_port, stream_tag, pkt_type, seq_num,
			total_packets,
		output ready
	);
endinterface

@@ hw/rtl/rba_rsp_if.sv @@
interface rba_rsp_if;
	import rba_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OUTCOME_W-1:0] outcome;
	logic [BUF_IDX_W-1:0] chosen_buffer;
	logic [PORT_W-1:0]    reply_port;
	logic [TAG_W-1:0]     ack_stream;
	logic [TYPE_W-1:0]    done_type;
	logic [RCNT_W-1:0]    released_count;

	modport source (
		output valid, outcome, chosen_buffer, reply_port, ack_stream, done_type,
			released_count,
		input  ready
	);
	modport sink (
		input  valid, outcome, chosen_buffer, reply_port, ack_stream, done_type,
			released_count,
		output ready
	);
endinterface

@@ hw/rtl/rba_cfg_if.sv @@
interface rba_cfg_if;
	import rba_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

@@ hw/rtl/rba_ram.sv @@
module rba_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, registered read that returns the old word during a write (read first).
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ hw/rtl/rba_unit.sv @@
module rba_unit #(
	parameter int FILL_W = 5,
	parameter int CAP_W  = 5,
	parameter int DEPTH  = 16
) (
	input  logic [FILL_W-1:0]           fill,
	input  logic [rba_pkg::SEQ_W-1:0]   tail_seq,
	input  logic [rba_pkg::TOTAL_W-1:0] tail_total,
	input  logic [rba_pkg::PORT_W-1:0]  tail_source,
	input  logic [CAP_W-1:0]            cap,
	input  logic [FILL_W-1:0]           best_fill,
	input  logic [rba_pkg::SEQ_W-1:0]   seq,
	input  logic [rba_pkg::TOTAL_W-1:0] total,
	input  logic [rba_pkg::PORT_W-1:0]  src,
	output rba_pkg::unit_flags_t        flags
);
	import rba_pkg::*;

	localparam int W0    = (FILL_W > CAP_W) ? FILL_W : CAP_W;
	localparam int SUM_W = ((W0 > TOTAL_W) ? W0 : TOTAL_W) + 1;

	logic             empty;
	logic             closed;
	logic [SUM_W-1:0] fill_x;
	logic [SUM_W-1:0] cap_x;
	logic [SUM_W-1:0] need;

	// A buffer is closed when it is empty or its last packet ends its stream.
	always_comb begin
		empty  = (fill == '0);
		closed = empty || ({1'b0, tail_seq} + 9'd1 == {1'b0, tail_total});
		fill_x = SUM_W'(fill);
		cap_x  = SUM_W'(cap);
		need   = fill_x + SUM_W'(total);
	end

	// Eligibility for a first packet, match for a later one, room and balance compare.
	always_comb begin
		flags.eligible = closed && (fill_x < cap_x) && (need <= cap_x);
		flags.match    = !empty && (tail_seq == seq - SEQ_W'(1)) && (tail_source == src);
		flags.room     = (SUM_W'(fill) < SUM_W'(DEPTH));
		flags.shorter  = (fill < best_fill);
	end

endmodule

@@ hw/rtl/reassembly_buffer_allocator.sv @@
// Reassembly buffer allocator. Each accepted word is either a packet header or a
// release command for one of the four buffers, and each produces exactly one result
// word. A single compare unit inspects one buffer per cycle under a small sequencer,
// so a packet is scanned across all NUM_BUFFERS buffers, then its record is stored
// and the result handed over; a dropped packet is not stored. In round robin mode a
// first packet then reduces the pointer modulo the eligible count and walks to the
// chosen eligible buffer. A release reads the head record through the registered
// read of the record memory before it updates the buffer, and skips the update when
// the buffer is empty. The sequencer passes through idle after every word before the
// next is taken, and a result that cannot leave the output register holds the
// sequencer in its last step. The block accepts a new word only in idle,
// but a finished result may still wait at the output while the next word is taken.
// Configuration writes are always taken and must be issued while the block is idle.
module reassembly_buffer_allocator #(
	parameter int BUFFER_DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	rba_req_if.sink   req,
	rba_rsp_if.source rsp,
	rba_cfg_if.sink   cfg
);
	import rba_pkg::*;

	localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
	localparam int PTR_W  = $clog2(BUFFER_DEPTH);
	localparam int CAP_W  = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;
	localparam int ADDR_W = $clog2(NUM_BUFFERS * BUFFER_DEPTH);
	localparam int HSUM_W = FILL_W + 1;
	localparam int CMP_W  = (TOTAL_W > FILL_W) ? TOTAL_W : FILL_W;

	// Configuration registers.
	logic               mode_q;
	logic [LIMIT_W-1:0] limit_q;

	// Per-buffer state.
	logic [FILL_W-1:0]  fill_q   [NUM_BUFFERS];
	logic [SEQ_W-1:0]   tseq_q   [NUM_BUFFERS];
	logic [TOTAL_W-1:0] ttotal_q [NUM_BUFFERS];
	logic [PORT_W-1:0]  tsrc_q   [NUM_BUFFERS];
	logic [PTR_W-1:0]   head_q   [NUM_BUFFERS];
	logic [PTR_W-1:0]   tail_q   [NUM_BUFFERS];
	logic [BUF_IDX_W-1:0] rr_q;

	// Captured word.
	logic [BUF_IDX_W-1:0] bidx_q;
	logic [PORT_W-1:0]    src_q;
	logic [TAG_W-1:0]     tag_q;
	logic [TYPE_W-1:0]    type_q;
	logic [SEQ_W-1:0]     seq_q;
	logic [TOTAL_W-1:0]   total_q;

	// Scan bookkeeping.
	state_t               state_q, state_d;
	logic [BUF_IDX_W-1:0] idx_q;
	logic                 found_q, found_d;
	logic                 ok_q, ok_d;
	logic [BUF_IDX_W-1:0] chosen_q, chosen_d;
	logic [FILL_W-1:0]    best_q, best_d;
	logic [NUM_BUFFERS-1:0] elig_q;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [CNT_W-1:0]     pos_q;
	logic [CNT_W-1:0]     k_q;

	// Pending result and output register.
	outcome_t             res_outcome_q;
	logic [BUF_IDX_W-1:0] res_buf_q;
	logic [PORT_W-1:0]    res_port_q;
	logic [TAG_W-1:0]     res_tag_q;
	logic [TYPE_W-1:0]    res_type_q;
	logic [RCNT_W-1:0]    res_cnt_q;
	logic                 rsp_valid_q;
	outcome_t             rsp_outcome_q;
	logic [BUF_IDX_W-1:0] rsp_buf_q;
	logic [PORT_W-1:0]    rsp_port_q;
	logic [TAG_W-1:0]     rsp_tag_q;
	logic [TYPE_W-1:0]    rsp_type_q;
	logic [RCNT_W-1:0]    rsp_cnt_q;

	// Combinational helpers.
	logic                 accept;
	logic                 is_first;
	logic                 scan_last;
	logic                 pick_hit;
	logic                 out_free;
	logic [BUF_IDX_W-1:0] sel;
	logic [FILL_W-1:0]    sel_fill;
	logic [PTR_W-1:0]     sel_head;
	logic [PTR_W-1:0]     sel_tail;
	logic [CAP_W-1:0]     cap;
	unit_flags_t          flags;
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_addr;
	logic [REC_W-1:0]     ram_wdata;
	logic [REC_W-1:0]     ram_rdata;
	logic [TOTAL_W-1:0]   rd_total;
	logic [FILL_W-1:0]    rel_n;
	logic [HSUM_W-1:0]    head_sum;
	logic [PTR_W-1:0]     head_new;
	logic [PTR_W-1:0]     tail_new;
	logic [SEQ_W:0]       seq_inc;
	logic                 fill_ovf;

	// Buffer under inspection: scan index, chosen buffer or release target.
	always_comb begin
		unique case (state_q)
			ST_SCAN, ST_PICK: sel = idx_q;
			ST_PUSH:          sel = chosen_q;
			ST_RD, ST_REL:    sel = bidx_q;
			default:          sel = idx_q;
		endcase
		sel_fill = fill_q[sel];
		sel_head = head_q[sel];
		sel_tail = tail_q[sel];
		cap = (CAP_W'(limit_q) < CAP_W'(BUFFER_DEPTH)) ? CAP_W'(limit_q)
			: CAP_W'(BUFFER_DEPTH);
	end

	rba_unit #(
		.FILL_W (FILL_W),
		.CAP_W  (CAP_W),
		.DEPTH  (BUFFER_DEPTH)
	) u_unit (
		.fill        (sel_fill),
		.tail_seq    (tseq_q[sel]),
		.tail_total  (ttotal_q[sel]),
		.tail_source (tsrc_q[sel]),
		.cap         (cap),
		.best_fill   (best_q),
		.seq         (seq_q),
		.total       (total_q),
		.src         (src_q),
		.flags       (flags)
	);

	// Record store: one entry per packet, addressed by buffer and slot.
	always_comb begin
		ram_we    = (state_q == ST_PUSH);
		ram_addr  = ADDR_W'(sel) * ADDR_W'(BUFFER_DEPTH)
			+ ADDR_W'((state_q == ST_PUSH) ? sel_tail : sel_head);
		ram_wdata = {type_q, total_q, tag_q};
	end

	rba_ram #(
		.WIDTH (REC_W),
		.DEPTH (NUM_BUFFERS * BUFFER_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Scan step: fold this buffer's flags into the running choice.
	always_comb begin
		is_first  = (seq_q == '0);
		scan_last = (idx_q == BUF_IDX_W'(NUM_BUFFERS - 1));
		found_d   = found_q;
		ok_d      = ok_q;
		chosen_d  = chosen_q;
		best_d    = best_q;
		cnt_d     = cnt_q;
		if (is_first) begin
			if (flags.eligible) begin
				cnt_d = cnt_q + CNT_W'(1);
				if (!found_q || flags.shorter) begin
					found_d  = 1'b1;
					ok_d     = 1'b1;
					chosen_d = idx_q;
					best_d   = sel_fill;
				end
			end
		end else if (!found_q && flags.match) begin
			found_d  = 1'b1;
			ok_d     = flags.room;
			chosen_d = idx_q;
		end
		pick_hit = elig_q[idx_q] && (k_q == pos_q);
	end

	// Release and push arithmetic.
	always_comb begin
		rd_total = ram_rdata[TAG_W +: TOTAL_W];
		rel_n    = (CMP_W'(rd_total) < CMP_W'(sel_fill)) ? FILL_W'(rd_total) : sel_fill;
		head_sum = HSUM_W'(sel_head) + HSUM_W'(rel_n);
		head_new = (head_sum >= HSUM_W'(BUFFER_DEPTH))
			? PTR_W'(head_sum - HSUM_W'(BUFFER_DEPTH)) : PTR_W'(head_sum);
		tail_new = (HSUM_W'(sel_tail) == HSUM_W'(BUFFER_DEPTH - 1))
			? '0 : sel_tail + PTR_W'(1);
		seq_inc  = {1'b0, seq_q} + 9'd1;
	end

	// Handshake controls.
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		cfg.ready = 1'b1;
		accept    = req.valid && (state_q == ST_IDLE);
		out_free  = !rsp_valid_q || rsp.ready;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.cmd == CMD_RELEASE) ? ST_RD : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					priority if (is_first && mode_q == MODE_RR && cnt_d != '0) begin
						state_d = ST_MOD;
					end else if (ok_d) begin
						state_d = ST_PUSH;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_MOD:  state_d = (pos_q >= cnt_q) ? ST_MOD : ST_PICK;
			ST_PICK: state_d = pick_hit ? ST_PUSH : ST_PICK;
			ST_PUSH: state_d = ST_OUT;
			ST_RD:   state_d = (sel_fill == '0) ? ST_OUT : ST_REL;
			ST_REL:  state_d = ST_OUT;
			ST_OUT:  state_d = out_free ? ST_IDLE : ST_OUT;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_RESET;
			limit_q     <= LIMIT_RESET;
			rr_q        <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				fill_q[i]   <= '0;
				tseq_q[i]   <= '0;
				ttotal_q[i] <= '0;
				tsrc_q[i]   <= '0;
				head_q[i]   <= '0;
				tail_q[i]   <= '0;
			end
		end else begin
			state_q <= state_d;

			// Register writes.
			if (cfg.valid) begin
				if (cfg.reg_index == CFG_BALANCE_MODE) begin
					mode_q <= cfg.wdata[0];
				end else if (cfg.reg_index == CFG_BUFFER_LIMIT) begin
					limit_q <= cfg.wdata[LIMIT_W-1:0];
				end
			end

			// Round robin pointer advances past the chosen eligible position.
			if (state_q == ST_PICK && pick_hit) begin
				rr_q <= (pos_q + CNT_W'(1) == cnt_q) ? '0 : BUF_IDX_W'(pos_q + CNT_W'(1));
			end

			// Append a packet to its buffer.
			if (state_q == ST_PUSH) begin
				fill_q[sel]   <= sel_fill + FILL_W'(1);
				tail_q[sel]   <= tail_new;
				tseq_q[sel]   <= seq_q;
				ttotal_q[sel] <= total_q;
				tsrc_q[sel]   <= src_q;
			end

			// Drop the head stream of a buffer.
			if (state_q == ST_REL) begin
				fill_q[sel] <= sel_fill - rel_n;
				head_q[sel] <= head_new;
			end

			// Output register takes the result once the previous word has left.
			if (state_q == ST_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			bidx_q  <= req.buffer_index;
			src_q   <= req.source_port;
			tag_q   <= req.stream_tag;
			type_q  <= req.pkt_type;
			seq_q   <= req.seq_num;
			total_q <= req.total_packets;
			idx_q   <= '0;
			found_q <= 1'b0;
			ok_q    <= 1'b0;
			cnt_q   <= '0;
			elig_q  <= '0;
			best_q  <= '0;
		end

		unique case (state_q)
			ST_SCAN: begin
				found_q  <= found_d;
				ok_q     <= ok_d;
				chosen_q <= chosen_d;
				best_q   <= best_d;
				cnt_q    <= cnt_d;
				elig_q[idx_q] <= is_first && flags.eligible;
				idx_q    <= idx_q + BUF_IDX_W'(1);
				pos_q    <= CNT_W'(rr_q);
				k_q      <= '0;
				if (scan_last && !ok_d) begin
					res_outcome_q <= OUT_DROP;
					res_buf_q     <= '0;
					res_port_q    <= src_q;
					res_tag_q     <= '0;
					res_type_q    <= '0;
					res_cnt_q     <= '0;
				end
			end
			ST_MOD: begin
				// Reduce the pointer modulo the eligible count, one subtract a cycle.
				if (pos_q >= cnt_q) begin
					pos_q <= pos_q - cnt_q;
				end
				idx_q <= '0;
			end
			ST_PICK: begin
				if (elig_q[idx_q]) begin
					k_q <= k_q + CNT_W'(1);
				end
				if (pick_hit) begin
					chosen_q <= idx_q;
				end
				idx_q <= idx_q + BUF_IDX_W'(1);
			end
			ST_PUSH: begin
				res_buf_q <= chosen_q;
				res_cnt_q <= '0;
				if (seq_inc == {1'b0, total_q}) begin
					res_outcome_q <= OUT_DONE;
					res_port_q    <= '0;
					res_tag_q     <= tag_q;
					res_type_q    <= type_q;
				end else begin
					res_outcome_q <= OUT_MORE;
					res_port_q    <= src_q;
					res_tag_q     <= '0;
					res_type_q    <= '0;
				end
			end
			ST_RD: begin
				res_outcome_q <= OUT_REL_EMPTY;
				res_buf_q     <= bidx_q;
				res_port_q    <= '0;
				res_tag_q     <= '0;
				res_type_q    <= '0;
				res_cnt_q     <= '0;
			end
			ST_REL: begin
				res_outcome_q <= OUT_REL;
				res_tag_q     <= ram_rdata[TAG_W-1:0];
				res_type_q    <= ram_rdata[TAG_W + TOTAL_W +: TYPE_W];
				res_cnt_q     <= RCNT_W'(rel_n);
			end
			default: begin
			end
		endcase

		if (state_q == ST_OUT && out_free) begin
			rsp_outcome_q <= res_outcome_q;
			rsp_buf_q     <= res_buf_q;
			rsp_port_q    <= res_port_q;
			rsp_tag_q     <= res_tag_q;
			rsp_type_q    <= res_type_q;
			rsp_cnt_q     <= res_cnt_q;
		end
	end

	// Result port.
	always_comb begin
		rsp.valid          = rsp_valid_q;
		rsp.outcome        = rsp_outcome_q;
		rsp.chosen_buffer  = rsp_buf_q;
		rsp.reply_port     = rsp_port_q;
		rsp.ack_stream     = rsp_tag_q;
		rsp.done_type      = rsp_type_q;
		rsp.released_count = rsp_cnt_q;
	end

	// No buffer ever holds more packets than its store has slots.
	always_comb begin
		fill_ovf = 1'b0;
		for (int i = 0; i < NUM_BUFFERS; i++) begin
			fill_ovf = fill_ovf || (fill_q[i] > FILL_W'(BUFFER_DEPTH));
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n) !fill_ovf)
		else $error("buffer fill exceeds store depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("new word taken while the previous one is in work");

	a_drop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.outcome == OUT_DROP |->
			rsp.chosen_buffer == '0 && rsp.ack_stream == '0 && rsp.released_count == '0)
		else $error("dropped packet result carries buffer or stream fields");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUSH |-> sel_fill < FILL_W'(BUFFER_DEPTH))
		else $error("packet stored into a full buffer");

endmodule

@@ verif/reassembly_buffer_allocator_tb.sv @@
module reassembly_buffer_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rba_pkg::*;

	localparam int POOL_DEPTH    = 16;
	localparam int SLOT_W        = $clog2(POOL_DEPTH);
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 24;
	localparam int PHASES        = 9;
	localparam int PRINT_CAP     = 60;

	// One request word as the sender sees it.
	typedef struct packed {
		logic                 cmd;
		logic [BUF_IDX_W-1:0] bidx;
		logic [PORT_W-1:0]    src;
		logic [TAG_W-1:0]     tag;
		logic [TYPE_W-1:0]    ftype;
		logic [SEQ_W-1:0]     seq;
		logic [TOTAL_W-1:0]   total;
	} req_word_t;

	// One result word, compared as a whole.
	typedef struct packed {
		outcome_t             outcome;
		logic [BUF_IDX_W-1:0] bsel;
		logic [PORT_W-1:0]    port;
		logic [TAG_W-1:0]     ack;
		logic [TYPE_W-1:0]    done_type;
		logic [RCNT_W-1:0]    count;
	} reply_t;

	// Packet record kept per buffer slot.
	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [TOTAL_W-1:0] total;
		logic [TYPE_W-1:0]  ftype;
	} stream_rec_t;

	// A stream that the sender is still emitting.
	typedef struct {
		logic [PORT_W-1:0]  src;
		logic [TAG_W-1:0]   tag;
		logic [TYPE_W-1:0]  ftype;
		logic [TOTAL_W-1:0] total;
		logic [SEQ_W-1:0]   next_seq;
	} open_stream_t;

	// Tracks the buffer pool and holds the replies still owed by the block.
	class pool_tracker;
		logic                 mode;
		logic [LIMIT_W-1:0]   limit;
		logic [RCNT_W-1:0]    fill[NUM_BUFFERS];
		logic [SEQ_W-1:0]     tail_seq[NUM_BUFFERS];
		logic [TOTAL_W-1:0]   tail_total[NUM_BUFFERS];
		logic [PORT_W-1:0]    tail_src[NUM_BUFFERS];
		logic [SLOT_W-1:0]    head[NUM_BUFFERS];
		logic [SLOT_W-1:0]    tail[NUM_BUFFERS];
		stream_rec_t          records[NUM_BUFFERS][POOL_DEPTH];
		int                   rr;
		reply_t               replies_due[$];
		int                   mismatches;
		int                   words;
		int                   outcome_seen[5];

		function new();
			mode = MODE_RESET;
			limit = LIMIT_RESET;
			rr = 0;
			mismatches = 0;
			words = 0;
			foreach (fill[b]) begin
				fill[b] = '0;
				tail_seq[b] = '0;
				tail_total[b] = '0;
				tail_src[b] = '0;
				head[b] = '0;
				tail[b] = '0;
			end
			foreach (outcome_seen[k])
				outcome_seen[k] = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_BALANCE_MODE)
				mode = val[0];
			else if (idx == CFG_BUFFER_LIMIT)
				limit = val[LIMIT_W-1:0];
		endfunction

		// Apply one accepted word to the pool and queue the reply it owes.
		function void take_word(req_word_t w);
			reply_t      r;
			stream_rec_t rec;
			int          elig[$];
			int          cap;
			int          f;
			int          n;
			int          pick;
			bit          closed;
			r = '0;
			pick = -1;
			words++;
			cap = (limit < POOL_DEPTH) ? int'(limit) : POOL_DEPTH;
			if (w.cmd == CMD_RELEASE) begin
				r.bsel = w.bidx;
				if (fill[w.bidx] == 0) begin
					r.outcome = OUT_REL_EMPTY;
				end else begin
					// The head stream leaves, but never more packets than are held.
					rec = records[w.bidx][head[w.bidx]];
					n = (int'(rec.total) < int'(fill[w.bidx])) ? int'(rec.total)
						: int'(fill[w.bidx]);
					head[w.bidx] = head[w.bidx] + n[SLOT_W-1:0];
					fill[w.bidx] = fill[w.bidx] - n[RCNT_W-1:0];
					r.outcome = OUT_REL;
					r.ack = rec.tag;
					r.done_type = rec.ftype;
					r.count = n[RCNT_W-1:0];
				end
				replies_due.insert(replies_due.size(), r);
				return;
			end
			if (w.seq == 0) begin
				// A new stream needs a closed buffer with room for all of it.
				for (int b = 0; b < NUM_BUFFERS; b++) begin
					f = int'(fill[b]);
					closed = (f == 0) || (int'(tail_seq[b]) + 1 == int'(tail_total[b]));
					if (closed && f < cap && cap - f >= int'(w.total))
						elig.insert(elig.size(), b);
				end
				if (elig.size() > 0) begin
					if (mode == MODE_JSQ) begin
						pick = elig[0];
						foreach (elig[i])
							if (fill[elig[i]] < fill[pick])
								pick = elig[i];
					end else begin
						n = rr % elig.size();
						pick = elig[n];
						rr = (n + 1) % elig.size();
					end
				end
			end else begin
				// A later packet follows its predecessor from the same port.
				for (int b = 0; b < NUM_BUFFERS; b++) begin
					if (fill[b] != 0 && tail_seq[b] == w.seq - 8'd1 && tail_src[b] == w.src) begin
						if (fill[b] < POOL_DEPTH)
							pick = b;
						break;
					end
				end
			end
			if (pick < 0) begin
				r.outcome = OUT_DROP;
				r.port = w.src;
			end else begin
				records[pick][tail[pick]] = '{tag: w.tag, total: w.total, ftype: w.ftype};
				tail[pick] = tail[pick] + 1'b1;
				fill[pick] = fill[pick] + 1'b1;
				tail_seq[pick] = w.seq;
				tail_total[pick] = w.total;
				tail_src[pick] = w.src;
				r.bsel = pick[BUF_IDX_W-1:0];
				if (int'(w.seq) + 1 == int'(w.total)) begin
					r.outcome = OUT_DONE;
					r.ack = w.tag;
					r.done_type = w.ftype;
				end else begin
					r.outcome = OUT_MORE;
					r.port = w.src;
				end
			end
			replies_due.insert(replies_due.size(), r);
		endfunction

		// Compare one delivered result word with the oldest reply owed.
		function void match_reply(reply_t got);
			reply_t want;
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= PRINT_CAP)
					$display("%0t: result word with nothing owed: outcome %0d buffer %0d",
						$time, got.outcome, got.bsel);
				return;
			end
			want = replies_due.pop_front();
			outcome_seen[want.outcome]++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= PRINT_CAP) begin
					$display("%0t: expected outcome %0d buffer %0d port %0d stream %0d type %0d count %0d",
						$time, want.outcome, want.bsel, want.port, want.ack, want.done_type,
						want.count);
					$display("%0t:   actual outcome %0d buffer %0d port %0d stream %0d type %0d count %0d",
						$time, got.outcome, got.bsel, got.port, got.ack, got.done_type,
						got.count);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	bit          rx_calm = 1'b1;
	bit          rx_open = 1'b1;
	int          rx_left = 0;
	int          quiet_cycles = 0;
	pool_tracker tracker = new();
	open_stream_t live_streams[$];

	rba_req_if req_bus();
	rba_rsp_if rsp_bus();
	rba_cfg_if cfg_bus();

	reassembly_buffer_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The result side alternates open and stalled runs unless held open.
	assign rsp_bus.ready = rx_calm | rx_open;

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_open = ~rx_open;
			rx_left = rx_open ? $urandom_range(1, 10) : $urandom_range(1, 12);
		end
		rx_left--;
	end

	// Sample every handshake at the rising edge and watch for a hang.
	always @(posedge clk) begin
		req_word_t seen;
		reply_t    got;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				got.outcome = outcome_t'(rsp_bus.outcome);
				got.bsel = rsp_bus.chosen_buffer;
				got.port = rsp_bus.reply_port;
				got.ack = rsp_bus.ack_stream;
				got.done_type = rsp_bus.done_type;
				got.count = rsp_bus.released_count;
				tracker.match_reply(got);
			end
			if (req_bus.valid && req_bus.ready) begin
				seen.cmd = req_bus.cmd;
				seen.bidx = req_bus.buffer_index;
				seen.src = req_bus.source_port;
				seen.tag = req_bus.stream_tag;
				seen.ftype = req_bus.pkt_type;
				seen.seq = req_bus.seq_num;
				seen.total = req_bus.total_packets;
				tracker.take_word(seen);
			end
			if (cfg_bus.valid && cfg_bus.ready)
				tracker.set_register(cfg_bus.reg_index, cfg_bus.wdata);
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
					(cfg_bus.valid && cfg_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic req_word_t make_arrival(logic [7:0] src, logic [7:0] tag,
			logic [1:0] ftype, logic [7:0] seq, logic [7:0] total);
		req_word_t w;
		w = '{cmd: CMD_ARRIVE, bidx: 2'($urandom_range(0, 3)), src: src, tag: tag,
			ftype: ftype, seq: seq, total: total};
		return w;
	endfunction

	function automatic req_word_t make_release(logic [BUF_IDX_W-1:0] bidx);
		req_word_t w;
		w = req_word_t'({$urandom(), $urandom()});
		w.cmd = CMD_RELEASE;
		w.bidx = bidx;
		return w;
	endfunction

	// Mostly well-formed interleaved streams, with releases, noise and broken sequences.
	function automatic req_word_t next_word();
		req_word_t    w;
		open_stream_t s;
		int           pick;
		int           k;
		int           r;
		w = req_word_t'({$urandom(), $urandom()});
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			w.cmd = CMD_RELEASE;
			return w;
		end
		w.cmd = CMD_ARRIVE;
		if (pick < 30) begin
			// Noise: any header, never a zero total since that pins a buffer for good.
			if ($urandom_range(0, 1))
				w.seq = SEQ_W'($urandom_range(0, 3));
			w.total = TOTAL_W'($urandom_range(1, 255));
			return w;
		end
		if (live_streams.size() == 0 || (live_streams.size() < 5 && $urandom_range(0, 3) == 0)) begin
			s.src = PORT_W'($urandom_range(0, 255));
			if ($urandom_range(0, 3) == 0)
				s.src = PORT_W'($urandom_range(0, 3));
			s.tag = TAG_W'($urandom_range(0, 255));
			s.ftype = TYPE_W'($urandom_range(0, 3));
			r = $urandom_range(0, 99);
			if (r < 80)
				s.total = TOTAL_W'($urandom_range(1, 6));
			else if (r < 97)
				s.total = TOTAL_W'($urandom_range(1, POOL_DEPTH));
			else
				s.total = TOTAL_W'($urandom_range(POOL_DEPTH + 1, 255));
			s.next_seq = '0;
			live_streams.insert(live_streams.size(), s);
		end
		k = $urandom_range(0, live_streams.size() - 1);
		s = live_streams[k];
		w.src = s.src;
		w.tag = s.tag;
		w.ftype = s.ftype;
		w.total = s.total;
		w.seq = s.next_seq;
		r = $urandom_range(0, 99);
		if (r < 4)
			w.seq = s.next_seq + 8'd1;
		else if (r < 6)
			w.src = ~s.src;
		s.next_seq = s.next_seq + 8'd1;
		if (s.next_seq >= s.total || s.total > POOL_DEPTH || $urandom_range(0, 59) == 0)
			live_streams.delete(k);
		else
			live_streams[k] = s;
		return w;
	endfunction

	// Present one word from a falling edge and hold it until it is taken.
	task automatic drive_word(input req_word_t w);
		req_bus.cmd = w.cmd;
		req_bus.buffer_index = w.bidx;
		req_bus.source_port = w.src;
		req_bus.stream_tag = w.tag;
		req_bus.pkt_type = w.ftype;
		req_bus.seq_num = w.seq;
		req_bus.total_packets = w.total;
		req_bus.valid = 1'b1;
		do @(posedge clk); while (!req_bus.ready);
		@(negedge clk);
	endtask

	task automatic send_list(input req_word_t words[$]);
		foreach (words[i])
			drive_word(words[i]);
		req_bus.valid = 1'b0;
	endtask

	task automatic drain_replies();
		req_bus.valid = 1'b0;
		while (tracker.replies_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_bus.reg_index = idx;
		cfg_bus.wdata = val;
		cfg_bus.valid = 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// Random traffic in bursts, one full drain midway and a calm stretch at the end.
	task automatic run_phase(input int count);
		int burst;
		int pause_at;
		burst = 0;
		pause_at = $urandom_range(count / 4, count / 2);
		for (int i = 0; i < count; i++) begin
			rx_calm = (i >= count - count / 5);
			if (i == pause_at) begin
				drain_replies();
				burst = 0;
			end
			if (burst == 0) begin
				if (!rx_calm) begin
					req_bus.valid = 1'b0;
					repeat ($urandom_range(1, 15)) @(negedge clk);
				end
				burst = $urandom_range(1, 12);
			end
			drive_word(next_word());
			burst--;
		end
		req_bus.valid = 1'b0;
		rx_calm = 1'b0;
	endtask

	initial begin
		req_word_t plan[$];
		int        phase_mode[PHASES]  = '{0, 1, 0, 1, 0, 1, 0, 1, 0};
		int        phase_limit[PHASES] = '{10, 16, 1, 1, 16, 0, 31, -1, -1};
		int        phase_items[PHASES] = '{180, 180, 150, 150, 180, 60, 180, 180, 180};
		int        lim;

		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.cmd = CMD_ARRIVE;
		req_bus.buffer_index = '0;
		req_bus.source_port = '0;
		req_bus.stream_tag = '0;
		req_bus.pkt_type = '0;
		req_bus.seq_num = '0;
		req_bus.total_packets = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.reg_index = '0;
		cfg_bus.wdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		rx_calm = 1'b0;

		// Under the reset settings: a ten-packet stream that keeps going past the
		// limit until the store is full, then small streams, misses and releases.
		for (int s = 0; s < POOL_DEPTH; s++)
			plan.insert(plan.size(), make_arrival(8'hA5, 8'h3C, 2'd2, s[7:0], 8'd10));
		plan.insert(plan.size(), make_arrival(8'hA5, 8'h3C, 2'd2, 8'd16, 8'd10));
		plan.insert(plan.size(), make_arrival(8'hFF, 8'h00, 2'd3, 8'd0, 8'd2));
		plan.insert(plan.size(), make_arrival(8'h00, 8'hFF, 2'd0, 8'd0, 8'd1));
		plan.insert(plan.size(), make_arrival(8'hFF, 8'h00, 2'd3, 8'd1, 8'd2));
		plan.insert(plan.size(), make_arrival(8'h5A, 8'hC3, 2'd1, 8'd255, 8'd255));
		plan.insert(plan.size(), make_arrival(8'h81, 8'h7E, 2'd1, 8'd0, 8'd255));
		plan.insert(plan.size(), make_release(2'd3));
		plan.insert(plan.size(), make_release(2'd0));
		plan.insert(plan.size(), make_release(2'd1));
		send_list(plan);
		run_phase(150);

		// Each later phase runs under its own register setting.
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_replies();
			repeat (SETTLE_CYCLES) @(negedge clk);
			lim = (phase_limit[phase] < 0) ? $urandom_range(2, 15) : phase_limit[phase];
			write_register(CFG_BUFFER_LIMIT, CFG_DATA_W'(lim));
			write_register(CFG_BALANCE_MODE, CFG_DATA_W'(phase_mode[phase]));
			run_phase(phase_items[phase]);
		end

		// A stream of zero total pins its buffer, so it comes last: clear the pool,
		// place one, extend it, and release every buffer.
		drain_replies();
		plan.delete();
		for (int r = 0; r < 2 * NUM_BUFFERS; r++)
			plan.insert(plan.size(), make_release(r[BUF_IDX_W-1:0]));
		plan.insert(plan.size(), make_arrival(8'h42, 8'h99, 2'd1, 8'd0, 8'd0));
		plan.insert(plan.size(), make_arrival(8'h42, 8'h99, 2'd1, 8'd1, 8'd0));
		for (int r = 0; r < NUM_BUFFERS; r++)
			plan.insert(plan.size(), make_release(r[BUF_IDX_W-1:0]));
		send_list(plan);

		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d words over %0d register settings with random stalls on both sides.",
			tracker.words, PHASES + 1);
		$display("Results: %0d queued, %0d completed, %0d dropped, %0d released, %0d empty releases.",
			tracker.outcome_seen[OUT_MORE], tracker.outcome_seen[OUT_DONE],
			tracker.outcome_seen[OUT_DROP], tracker.outcome_seen[OUT_REL],
			tracker.outcome_seen[OUT_REL_EMPTY]);
		if (tracker.mismatches == 0 && tracker.replies_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ reassembly_buffer_allocator.f @@
hw/rtl/rba_pkg.sv
hw/rtl/rba_req_if.sv
hw/rtl/rba_rsp_if.sv
hw/rtl/rba_cfg_if.sv
hw/rtl/rba_ram.sv
hw/rtl/rba_unit.sv
hw/rtl/reassembly_buffer_allocator.sv
verif/reassembly_buffer_allocator_tb.sv
